FILE: design/pbr_pkg.sv
// Package: shared constants, command codes and controller/datapath interface types.
`timescale 1ns / 1ps
package pbr_pkg;

  localparam int DEF_POOL_SLOTS = 16;

  localparam int FILE_W   = 16;
  localparam int PAGE_W   = 32;
  localparam int HANDLE_W = 32;
  localparam int KEY_W    = FILE_W + PAGE_W;
  localparam int ENTRY_W  = KEY_W + HANDLE_W;
  localparam int MODE_W   = 2;
  localparam int LIMIT_W  = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam int LFSR_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'd1;

  localparam logic [MODE_W-1:0] MODE_LRU    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLOCK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RSVD   = 2'd3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
  localparam logic [LFSR_W-1:0]  LFSR_SEED   = 16'hACE1;
  localparam logic [LFSR_W-1:0]  LFSR_TAPS   = 16'hB400;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
  localparam logic [OP_W-1:0] OP_RD_IDX    = 4'd2;
  localparam logic [OP_W-1:0] OP_CMP       = 4'd3;
  localparam logic [OP_W-1:0] OP_HIT       = 4'd4;
  localparam logic [OP_W-1:0] OP_SET_IDX0  = 4'd5;
  localparam logic [OP_W-1:0] OP_LRU_STEP  = 4'd6;
  localparam logic [OP_W-1:0] OP_CLK_STEP  = 4'd7;
  localparam logic [OP_W-1:0] OP_LFSR      = 4'd8;
  localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd9;
  localparam logic [OP_W-1:0] OP_RND_STEP  = 4'd10;
  localparam logic [OP_W-1:0] OP_VRD       = 4'd11;
  localparam logic [OP_W-1:0] OP_DROP      = 4'd12;
  localparam logic [OP_W-1:0] OP_FREE_STEP = 4'd13;
  localparam logic [OP_W-1:0] OP_INSERT    = 4'd14;
  localparam logic [OP_W-1:0] OP_PUBLISH   = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic              kind;
    logic [MODE_W-1:0] mode;
    logic              need_evict;
    logic              match;
    logic              idx_last;
    logic              clk_hit;
    logic              step_last;
    logic              div_last;
    logic              rnd_hit;
    logic              free_now;
  } status_t;

endpackage

FILE: design/pbr_ctrl.sv
// Controller: sequences lookup, victim selection, eviction and insert per transaction.
`timescale 1ns / 1ps
module pbr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  pbr_pkg::status_t sts,
  output pbr_pkg::cmd_t   cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CMP  = 4'd2;
  localparam logic [3:0] S_HIT  = 4'd3;
  localparam logic [3:0] S_MISS = 4'd4;
  localparam logic [3:0] S_LRU0 = 4'd5;
  localparam logic [3:0] S_LRU  = 4'd6;
  localparam logic [3:0] S_CLK  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_RND  = 4'd9;
  localparam logic [3:0] S_VRD  = 4'd10;
  localparam logic [3:0] S_DROP = 4'd11;
  localparam logic [3:0] S_FREE = 4'd12;
  localparam logic [3:0] S_INS  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = pbr_pkg::OP_NONE;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = pbr_pkg::OP_LOAD;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.op    = pbr_pkg::OP_RD_IDX;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.op = pbr_pkg::OP_CMP;
        if (sts.match) begin
          state_nxt = S_HIT;
        end else if (sts.idx_last) begin
          state_nxt = S_MISS;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_HIT: begin
        cmd.op    = pbr_pkg::OP_HIT;
        state_nxt = S_DONE;
      end
      S_MISS: begin
        if (sts.kind == pbr_pkg::KIND_GET) begin
          state_nxt = S_DONE;
        end else if (!sts.need_evict) begin
          cmd.op    = pbr_pkg::OP_SET_IDX0;
          state_nxt = S_FREE;
        end else if (sts.mode == pbr_pkg::MODE_CLOCK) begin
          state_nxt = S_CLK;
        end else if (sts.mode == pbr_pkg::MODE_RANDOM) begin
          cmd.op    = pbr_pkg::OP_LFSR;
          state_nxt = S_DIV;
        end else begin
          cmd.op    = pbr_pkg::OP_SET_IDX0;
          state_nxt = S_LRU;
        end
      end
      S_LRU0: begin
        cmd.op    = pbr_pkg::OP_SET_IDX0;
        state_nxt = S_LRU;
      end
      S_LRU: begin
        cmd.op = pbr_pkg::OP_LRU_STEP;
        if (sts.idx_last) state_nxt = S_VRD;
      end
      S_CLK: begin
        cmd.op = pbr_pkg::OP_CLK_STEP;
        if (sts.clk_hit) begin
          state_nxt = S_VRD;
        end else if (sts.step_last) begin
          state_nxt = S_LRU0;
        end
      end
      S_DIV: begin
        cmd.op = pbr_pkg::OP_DIV_STEP;
        if (sts.div_last) state_nxt = S_RND;
      end
      S_RND: begin
        cmd.op = pbr_pkg::OP_RND_STEP;
        if (sts.rnd_hit) begin
          state_nxt = S_VRD;
        end else if (sts.idx_last) begin
          state_nxt = S_LRU0;
        end
      end
      S_VRD: begin
        cmd.op    = pbr_pkg::OP_VRD;
        state_nxt = S_DROP;
      end
      S_DROP: begin
        cmd.op    = pbr_pkg::OP_DROP;
        state_nxt = (sts.mode == pbr_pkg::MODE_CLOCK) ? S_INS : S_FREE;
      end
      S_FREE: begin
        cmd.op = pbr_pkg::OP_FREE_STEP;
        if (sts.free_now) begin
          state_nxt = S_INS;
        end else if (sts.idx_last) begin
          state_nxt = S_DONE;
        end
      end
      S_INS: begin
        cmd.op    = pbr_pkg::OP_INSERT;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = pbr_pkg::OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a finished result never lands on top of one still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == pbr_pkg::OP_PUBLISH) |-> (!out_valid_r || out_tready))
    else $error("result overwritten before taken");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_RD))
    else $error("accepted transaction did not start lookup");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |-> (sts.kind == pbr_pkg::KIND_PUT))
    else $error("insert on a get");

endmodule

FILE: design/pbr_dpath.sv
// Datapath: slot store, replacement state, victim search units and result registers.
`timescale 1ns / 1ps
module pbr_dpath #(
  parameter int POOL_SLOTS = pbr_pkg::DEF_POOL_SLOTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pbr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_kind,
  input  logic [pbr_pkg::FILE_W-1:0]        in_file_id,
  input  logic [pbr_pkg::PAGE_W-1:0]        in_page_number,
  input  logic [pbr_pkg::HANDLE_W-1:0]      in_page_handle,
  input  pbr_pkg::cmd_t                     cmd,
  output pbr_pkg::status_t                  sts,
  output logic                              out_hit,
  output logic [pbr_pkg::HANDLE_W-1:0]      out_found_handle,
  output logic                              out_evicted,
  output logic [pbr_pkg::FILE_W-1:0]        out_victim_file_id,
  output logic [pbr_pkg::PAGE_W-1:0]        out_victim_page_number
);

  localparam int IW = $clog2(POOL_SLOTS);
  localparam int OW = $clog2(POOL_SLOTS + 1);
  localparam int CW = (OW > pbr_pkg::LIMIT_W) ? OW : pbr_pkg::LIMIT_W;
  localparam int SW = $clog2(2 * POOL_SLOTS + 2);
  localparam logic [IW-1:0] IDX_MAX  = IW'(POOL_SLOTS - 1);
  localparam logic [SW-1:0] STEP_MAX = SW'(2 * POOL_SLOTS + 1);

  localparam int FL = 0;
  localparam int PL = pbr_pkg::FILE_W;
  localparam int HL = pbr_pkg::KEY_W;

  // slot store: {handle, page, file}
  logic [pbr_pkg::ENTRY_W-1:0] mem [POOL_SLOTS];
  logic [pbr_pkg::ENTRY_W-1:0] rd_q;
  logic                        mem_we, mem_re;
  logic [IW-1:0]               mem_waddr, mem_raddr;
  logic [pbr_pkg::ENTRY_W-1:0] mem_wdata;

  logic [pbr_pkg::MODE_W-1:0]  mode_r;
  logic [pbr_pkg::LIMIT_W-1:0] limit_r;

  logic                  valid_r [POOL_SLOTS];
  logic                  valid_nxt [POOL_SLOTS];
  logic                  ref_r [POOL_SLOTS];
  logic                  ref_nxt [POOL_SLOTS];
  logic [IW-1:0]         rec_r [POOL_SLOTS];
  logic [IW-1:0]         rec_nxt [POOL_SLOTS];
  logic [IW-1:0]         hand_r, hand_nxt;
  logic [OW-1:0]         occ_r, occ_nxt;
  logic [pbr_pkg::LFSR_W-1:0] lfsr_r, lfsr_nxt;

  logic                  kind_r, kind_nxt;
  logic [pbr_pkg::FILE_W-1:0]   file_r, file_nxt;
  logic [pbr_pkg::PAGE_W-1:0]   page_r, page_nxt;
  logic [pbr_pkg::HANDLE_W-1:0] handle_r, handle_nxt;

  logic [IW-1:0]         idx_r, idx_nxt, idx_inc;
  logic [IW-1:0]         victim_r, victim_nxt;
  logic [IW-1:0]         best_rec_r, best_rec_nxt;
  logic                  best_ok_r, best_ok_nxt;
  logic [SW-1:0]         step_r, step_nxt;
  logic [pbr_pkg::LFSR_W-1:0] dvd_r, dvd_nxt;
  logic [OW-1:0]         rem_r, rem_nxt;
  logic [3:0]            bcnt_r, bcnt_nxt;
  logic [OW-1:0]         seen_r, seen_nxt;
  logic [IW-1:0]         dest_r, dest_nxt;

  logic                          res_hit_r, res_hit_nxt;
  logic [pbr_pkg::HANDLE_W-1:0]  res_handle_r, res_handle_nxt;
  logic                          res_ev_r, res_ev_nxt;
  logic [pbr_pkg::FILE_W-1:0]    res_vf_r, res_vf_nxt;
  logic [pbr_pkg::PAGE_W-1:0]    res_vp_r, res_vp_nxt;

  logic [pbr_pkg::MODE_W-1:0] mode_eff;
  logic [CW-1:0]              lim_ext, cap;
  logic [OW:0]                rem_sh;
  logic [pbr_pkg::LFSR_W-1:0] lfsr_step;
  logic                       match_now, clk_hit_now, rnd_hit_now;

  assign mode_eff = (mode_r == pbr_pkg::MODE_RSVD) ? pbr_pkg::MODE_LRU : mode_r;
  assign lim_ext  = CW'(limit_r);
  always_comb begin
    if (lim_ext == '0) begin
      cap = CW'(1);
    end else if (lim_ext > CW'(POOL_SLOTS)) begin
      cap = CW'(POOL_SLOTS);
    end else begin
      cap = lim_ext;
    end
  end

  assign idx_inc   = (idx_r == IDX_MAX) ? '0 : idx_r + IW'(1);
  assign lfsr_step = lfsr_r[0] ? ((lfsr_r >> 1) ^ pbr_pkg::LFSR_TAPS) : (lfsr_r >> 1);
  assign rem_sh    = {rem_r, dvd_r[pbr_pkg::LFSR_W-1]};

  assign match_now   = valid_r[idx_r] && (rd_q[PL-1:FL] == file_r) &&
                       (rd_q[HL-1:PL] == page_r);
  assign clk_hit_now = valid_r[hand_r] && !ref_r[hand_r];
  assign rnd_hit_now = valid_r[idx_r] && (seen_r == rem_r);

  assign sts.kind       = kind_r;
  assign sts.mode       = mode_eff;
  assign sts.need_evict = CW'(occ_r) >= cap;
  assign sts.match      = match_now;
  assign sts.idx_last   = (idx_r == IDX_MAX);
  assign sts.clk_hit    = clk_hit_now;
  assign sts.step_last  = (step_r == STEP_MAX);
  assign sts.div_last   = (bcnt_r == 4'd15);
  assign sts.rnd_hit    = rnd_hit_now;
  assign sts.free_now   = !valid_r[idx_r];

  always_comb begin
    valid_nxt = valid_r;
    ref_nxt   = ref_r;
    rec_nxt   = rec_r;
    hand_nxt  = hand_r;
    occ_nxt   = occ_r;
    lfsr_nxt  = lfsr_r;
    kind_nxt  = kind_r;
    file_nxt  = file_r;
    page_nxt  = page_r;
    handle_nxt = handle_r;
    idx_nxt   = idx_r;
    victim_nxt = victim_r;
    best_rec_nxt = best_rec_r;
    best_ok_nxt  = best_ok_r;
    step_nxt  = step_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    bcnt_nxt  = bcnt_r;
    seen_nxt  = seen_r;
    dest_nxt  = dest_r;
    res_hit_nxt    = res_hit_r;
    res_handle_nxt = res_handle_r;
    res_ev_nxt     = res_ev_r;
    res_vf_nxt     = res_vf_r;
    res_vp_nxt     = res_vp_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = idx_r;
    mem_raddr = idx_r;
    mem_wdata = {handle_r, page_r, file_r};
    case (cmd.op)
      pbr_pkg::OP_LOAD: begin
        kind_nxt   = in_kind;
        file_nxt   = in_file_id;
        page_nxt   = in_page_number;
        handle_nxt = in_page_handle;
        idx_nxt    = '0;
        step_nxt   = '0;
        res_hit_nxt    = 1'b0;
        res_handle_nxt = '0;
        res_ev_nxt     = 1'b0;
        res_vf_nxt     = '0;
        res_vp_nxt     = '0;
      end
      pbr_pkg::OP_RD_IDX: begin
        mem_re = 1'b1;
      end
      pbr_pkg::OP_CMP: begin
        if (!match_now) idx_nxt = idx_inc;
      end
      pbr_pkg::OP_HIT: begin
        res_hit_nxt = 1'b1;
        if (kind_r == pbr_pkg::KIND_GET) begin
          res_handle_nxt = rd_q[pbr_pkg::ENTRY_W-1:HL];
        end else begin
          mem_we = 1'b1;
        end
        if (mode_eff == pbr_pkg::MODE_LRU) begin
          for (int t = 0; t < POOL_SLOTS; t++) begin
            if (valid_r[t] && rec_r[t] < rec_r[idx_r]) rec_nxt[t] = rec_r[t] + IW'(1);
          end
          rec_nxt[idx_r] = '0;
        end else if (mode_eff == pbr_pkg::MODE_CLOCK) begin
          ref_nxt[idx_r] = 1'b1;
        end
      end
      pbr_pkg::OP_SET_IDX0: begin
        idx_nxt     = '0;
        best_ok_nxt = 1'b0;
      end
      pbr_pkg::OP_LRU_STEP: begin
        if (valid_r[idx_r] && (!best_ok_r || rec_r[idx_r] > best_rec_r)) begin
          best_ok_nxt  = 1'b1;
          best_rec_nxt = rec_r[idx_r];
          victim_nxt   = idx_r;
        end
        idx_nxt = idx_inc;
      end
      pbr_pkg::OP_CLK_STEP: begin
        hand_nxt = (hand_r == IDX_MAX) ? '0 : hand_r + IW'(1);
        step_nxt = step_r + SW'(1);
        if (clk_hit_now) begin
          victim_nxt = hand_r;
        end else if (valid_r[hand_r]) begin
          ref_nxt[hand_r] = 1'b0;
        end
      end
      pbr_pkg::OP_LFSR: begin
        lfsr_nxt = lfsr_step;
        dvd_nxt  = lfsr_step;
        rem_nxt  = '0;
        bcnt_nxt = '0;
        idx_nxt  = '0;
        seen_nxt = '0;
      end
      pbr_pkg::OP_DIV_STEP: begin
        // restoring remainder, one dividend bit per cycle
        if (rem_sh >= (OW + 1)'(occ_r)) begin
          rem_nxt = OW'(rem_sh - (OW + 1)'(occ_r));
        end else begin
          rem_nxt = OW'(rem_sh);
        end
        dvd_nxt  = dvd_r << 1;
        bcnt_nxt = bcnt_r + 4'd1;
      end
      pbr_pkg::OP_RND_STEP: begin
        if (rnd_hit_now) begin
          victim_nxt = idx_r;
        end else if (valid_r[idx_r]) begin
          seen_nxt = seen_r + OW'(1);
        end
        idx_nxt     = idx_inc;
        best_ok_nxt = 1'b0;
      end
      pbr_pkg::OP_VRD: begin
        mem_re    = 1'b1;
        mem_raddr = victim_r;
      end
      pbr_pkg::OP_DROP: begin
        res_ev_nxt = 1'b1;
        res_vf_nxt = rd_q[PL-1:FL];
        res_vp_nxt = rd_q[HL-1:PL];
        for (int t = 0; t < POOL_SLOTS; t++) begin
          if (valid_r[t] && rec_r[t] > rec_r[victim_r]) rec_nxt[t] = rec_r[t] - IW'(1);
        end
        valid_nxt[victim_r] = 1'b0;
        ref_nxt[victim_r]   = 1'b0;
        rec_nxt[victim_r]   = '0;
        occ_nxt  = occ_r - OW'(1);
        dest_nxt = victim_r;
        idx_nxt  = '0;
      end
      pbr_pkg::OP_FREE_STEP: begin
        if (!valid_r[idx_r]) dest_nxt = idx_r;
        idx_nxt = idx_inc;
      end
      pbr_pkg::OP_INSERT: begin
        for (int t = 0; t < POOL_SLOTS; t++) begin
          if (valid_r[t]) rec_nxt[t] = rec_r[t] + IW'(1);
        end
        valid_nxt[dest_r] = 1'b1;
        ref_nxt[dest_r]   = (mode_eff == pbr_pkg::MODE_CLOCK);
        rec_nxt[dest_r]   = '0;
        occ_nxt   = occ_r + OW'(1);
        mem_we    = 1'b1;
        mem_waddr = dest_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= pbr_pkg::MODE_LRU;
      limit_r <= pbr_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == pbr_pkg::CFG_REPLACE_MODE) begin
        mode_r <= cfg_wdata[pbr_pkg::MODE_W-1:0];
      end else if (cfg_index == pbr_pkg::CFG_SLOTS_IN_USE) begin
        limit_r <= cfg_wdata[pbr_pkg::LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < POOL_SLOTS; t++) begin
        valid_r[t] <= 1'b0;
        ref_r[t]   <= 1'b0;
        rec_r[t]   <= '0;
      end
      hand_r    <= '0;
      occ_r     <= '0;
      lfsr_r    <= pbr_pkg::LFSR_SEED;
      idx_r     <= '0;
      step_r    <= '0;
      bcnt_r    <= '0;
      seen_r    <= '0;
      best_ok_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      ref_r     <= ref_nxt;
      rec_r     <= rec_nxt;
      hand_r    <= hand_nxt;
      occ_r     <= occ_nxt;
      lfsr_r    <= lfsr_nxt;
      idx_r     <= idx_nxt;
      step_r    <= step_nxt;
      bcnt_r    <= bcnt_nxt;
      seen_r    <= seen_nxt;
      best_ok_r <= best_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    file_r       <= file_nxt;
    page_r       <= page_nxt;
    handle_r     <= handle_nxt;
    victim_r     <= victim_nxt;
    best_rec_r   <= best_rec_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    dest_r       <= dest_nxt;
    res_hit_r    <= res_hit_nxt;
    res_handle_r <= res_handle_nxt;
    res_ev_r     <= res_ev_nxt;
    res_vf_r     <= res_vf_nxt;
    res_vp_r     <= res_vp_nxt;
    if (cmd.op == pbr_pkg::OP_PUBLISH) begin
      out_hit                <= res_hit_r;
      out_found_handle       <= res_handle_r;
      out_evicted            <= res_ev_r;
      out_victim_file_id     <= res_vf_r;
      out_victim_page_number <= res_vp_r;
    end
  end

  logic [POOL_SLOTS-1:0] valid_vec;
  always_comb begin
    for (int t = 0; t < POOL_SLOTS; t++) valid_vec[t] = valid_r[t];
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == 32'(occ_r))
    else $error("occupancy out of step with valid slots");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == pbr_pkg::OP_INSERT) |-> !valid_r[dest_r])
    else $error("insert into an occupied slot");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == pbr_pkg::OP_DROP) |-> valid_r[victim_r])
    else $error("eviction of an empty slot");

endmodule

FILE: design/page_buffer_replacement.sv
// Top level: page pool with LRU, clock and random replacement behind stream ports.
// One transaction at a time. A lookup reads the slot store slot by slot, a read state
// and then a compare state for each slot (registered read), and stops at the first
// match or after the last slot. A put that must evict adds the victim search: a step
// for every slot for least recently used, up to 2*POOL_SLOTS+2 hand steps for clock,
// 16 remainder steps plus up to POOL_SLOTS slots for random; then the victim is read
// and dropped, a free slot is searched (not for clock, which reuses the victim's
// slot) and the entry is inserted. A new item is taken while the previous result
// still waits on the output.
`timescale 1ns / 1ps
module page_buffer_replacement #(
  parameter int POOL_SLOTS = pbr_pkg::DEF_POOL_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [pbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // file_id[15:0], page_number[47:16], page_handle[79:48]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // found_handle[31:0], victim_file_id[47:32],
                                  // victim_page_number[79:48]
  output logic [1:0]  out_tuser   // hit[0], evicted[1]
);

  pbr_pkg::cmd_t    cmd;
  pbr_pkg::status_t sts;

  pbr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pbr_dpath #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dpath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_kind                (in_tuser),
    .in_file_id             (in_tdata[15:0]),
    .in_page_number         (in_tdata[47:16]),
    .in_page_handle         (in_tdata[79:48]),
    .cmd                    (cmd),
    .sts                    (sts),
    .out_hit                (out_tuser[0]),
    .out_found_handle       (out_tdata[31:0]),
    .out_evicted            (out_tuser[1]),
    .out_victim_file_id     (out_tdata[47:32]),
    .out_victim_page_number (out_tdata[79:48])
  );

endmodule

FILE: sim/pbr_checker.sv
// Checker: watches both stream channels and the config port, predicts and compares results.
`timescale 1ns / 1ps
module pbr_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [pbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          errors,
  output int          pending
);

  localparam int SLOTS = pbr_pkg::DEF_POOL_SLOTS;

  typedef struct packed {
    logic        hit;
    logic [31:0] found_handle;
    logic        evicted;
    logic [15:0] victim_file;
    logic [31:0] victim_page;
  } lookup_res_t;

  lookup_res_t expected_q[$];

  logic [pbr_pkg::MODE_W-1:0]  mode_q;
  logic [pbr_pkg::LIMIT_W-1:0] limit_q;
  logic               valid_a [SLOTS];
  logic               refbit_a[SLOTS];
  logic [15:0]        file_a  [SLOTS];
  logic [31:0]        page_a  [SLOTS];
  logic [31:0]        handle_a[SLOTS];
  int                 rank_a  [SLOTS];
  int                 hand_q, occ_q;
  logic [pbr_pkg::LFSR_W-1:0] lfsr_q;

  function automatic void pool_clear();
    mode_q = pbr_pkg::MODE_LRU;
    limit_q = pbr_pkg::LIMIT_RESET;
    for (int t = 0; t < SLOTS; t++) begin
      valid_a[t] = 1'b0; refbit_a[t] = 1'b0; file_a[t] = '0;
      page_a[t] = '0; handle_a[t] = '0; rank_a[t] = 0;
    end
    hand_q = 0;
    occ_q = 0;
    lfsr_q = pbr_pkg::LFSR_SEED;
  endfunction

  function automatic void touch(int s, logic [pbr_pkg::MODE_W-1:0] m);
    int r;
    if (m == pbr_pkg::MODE_LRU) begin
      r = rank_a[s];
      for (int t = 0; t < SLOTS; t++)
        if (valid_a[t] && rank_a[t] < r) rank_a[t]++;
      rank_a[s] = 0;
    end else if (m == pbr_pkg::MODE_CLOCK) begin
      refbit_a[s] = 1'b1;
    end
  endfunction

  function automatic void drop(int v);
    int r;
    r = rank_a[v];
    valid_a[v] = 1'b0;
    refbit_a[v] = 1'b0;
    for (int t = 0; t < SLOTS; t++)
      if (valid_a[t] && rank_a[t] > r) rank_a[t]--;
    rank_a[v] = 0;
    if (occ_q > 0) occ_q--;
  endfunction

  function automatic int oldest_slot();
    int best;
    best = -1;
    for (int t = 0; t < SLOTS; t++)
      if (valid_a[t] && (best < 0 || rank_a[t] > rank_a[best])) best = t;
    return best;
  endfunction

  function automatic int sweep_hand();
    int t;
    for (int n = 0; n < 2 * SLOTS + 2; n++) begin
      t = hand_q % SLOTS;
      hand_q = (t + 1) % SLOTS;
      if (valid_a[t]) begin
        if (!refbit_a[t]) return t;
        refbit_a[t] = 1'b0;
      end
    end
    return oldest_slot();
  endfunction

  function automatic int random_slot();
    logic lsb;
    int k, seen;
    lsb = lfsr_q[0];
    lfsr_q = lfsr_q >> 1;
    if (lsb) lfsr_q = lfsr_q ^ pbr_pkg::LFSR_TAPS;
    if (occ_q == 0) return -1;
    k = int'(lfsr_q) % occ_q;
    seen = 0;
    for (int t = 0; t < SLOTS; t++)
      if (valid_a[t]) begin
        if (seen == k) return t;
        seen++;
      end
    return oldest_slot();
  endfunction

  function automatic lookup_res_t pool_access(logic kind, logic [15:0] f, logic [31:0] p,
                                              logic [31:0] h);
    lookup_res_t r;
    logic [pbr_pkg::MODE_W-1:0] m;
    int cap, found, victim, dest;
    r = '0;
    m = (mode_q == pbr_pkg::MODE_RSVD) ? pbr_pkg::MODE_LRU : mode_q;
    found = -1; victim = -1; dest = -1;
    for (int t = 0; t < SLOTS; t++)
      if (found < 0 && valid_a[t] && file_a[t] == f && page_a[t] == p) found = t;
    if (found >= 0) begin
      r.hit = 1'b1;
      if (kind == pbr_pkg::KIND_GET) r.found_handle = handle_a[found];
      else handle_a[found] = h;
      touch(found, m);
      return r;
    end
    if (kind == pbr_pkg::KIND_GET) return r;
    cap = int'(limit_q);
    if (cap < 1) cap = 1;
    if (cap > SLOTS) cap = SLOTS;
    if (occ_q >= cap) begin
      if (m == pbr_pkg::MODE_CLOCK) victim = sweep_hand();
      else if (m == pbr_pkg::MODE_RANDOM) victim = random_slot();
      else victim = oldest_slot();
      if (victim >= 0) begin
        r.evicted = 1'b1;
        r.victim_file = file_a[victim];
        r.victim_page = page_a[victim];
        drop(victim);
      end
    end
    if (m == pbr_pkg::MODE_CLOCK && victim >= 0) dest = victim;
    else
      for (int t = SLOTS - 1; t >= 0; t--)
        if (!valid_a[t]) dest = t;
    if (dest < 0) return r;
    for (int t = 0; t < SLOTS; t++)
      if (valid_a[t]) rank_a[t]++;
    valid_a[dest] = 1'b1;
    file_a[dest] = f;
    page_a[dest] = p;
    handle_a[dest] = h;
    refbit_a[dest] = (m == pbr_pkg::MODE_CLOCK);
    rank_a[dest] = 0;
    occ_q++;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    lookup_res_t got, want;
    if (!rst_n) begin
      pool_clear();
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == pbr_pkg::CFG_REPLACE_MODE) mode_q = cfg_wdata[pbr_pkg::MODE_W-1:0];
        else if (cfg_index == pbr_pkg::CFG_SLOTS_IN_USE) limit_q = cfg_wdata;
      end
      // result transaction first: it belongs to an older item than a same-cycle input
      if (out_tvalid && out_tready) begin
        got.hit = out_tuser[0];
        got.evicted = out_tuser[1];
        got.found_handle = out_tdata[31:0];
        got.victim_file = out_tdata[47:32];
        got.victim_page = out_tdata[79:48];
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", {out_tuser, out_tdata[61:0]}, 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (got.hit !== want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
          if (got.found_handle !== want.found_handle)
            report_mismatch("found_handle", 64'(got.found_handle), 64'(want.found_handle));
          if (got.evicted !== want.evicted)
            report_mismatch("evicted", 64'(got.evicted), 64'(want.evicted));
          if (got.victim_file !== want.victim_file)
            report_mismatch("victim_file_id", 64'(got.victim_file), 64'(want.victim_file));
          if (got.victim_page !== want.victim_page)
            report_mismatch("victim_page_number", 64'(got.victim_page),
                            64'(want.victim_page));
        end
      end
      if (in_tvalid && in_tready)
        expected_q = {expected_q, pool_access(in_tuser, in_tdata[15:0], in_tdata[47:16],
                                              in_tdata[79:48])};
    end
  end
endmodule

FILE: sim/tb.sv
// Testbench top: drives page pool lookups and inserts under several policies and limits.
`timescale 1ns / 1ps
module tb;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [pbr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pbr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;   // file_id[15:0], page_number[47:16], page_handle[79:48]
  logic        in_tuser = 0;    // kind
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [79:0] out_tdata;       // found_handle[31:0], victim_file_id[47:32],
                                // victim_page_number[79:48]
  logic [1:0]  out_tuser;       // hit[0], evicted[1]
  int          errors, pending;
  bit          calm = 0;        // no idling on either side
  int          quiet_cnt = 0;
  int          stall_left = 0;

  logic [15:0] key_file[24];
  logic [31:0] key_page[24];

  logic [pbr_pkg::MODE_W-1:0] modes[10] = '{pbr_pkg::MODE_LRU, pbr_pkg::MODE_CLOCK,
    pbr_pkg::MODE_RANDOM, pbr_pkg::MODE_RSVD, pbr_pkg::MODE_CLOCK, pbr_pkg::MODE_LRU,
    pbr_pkg::MODE_RANDOM, pbr_pkg::MODE_CLOCK, pbr_pkg::MODE_LRU, pbr_pkg::MODE_RANDOM};
  int          limits[10] = '{16, 16, 16, 4, 1, 0, 31, 5, 2, 3};

  always #6 clk = ~clk;

  page_buffer_replacement dut (.*);

  pbr_checker u_checker (.*);

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 12);
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt > 6000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [pbr_pkg::CFG_IDX_W-1:0] idx,
                           logic [pbr_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic send(logic kind, logic [15:0] f, logic [31:0] p, logic [31:0] h);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= {h, p, f};
    forever begin
      @(negedge clk);
      if (in_tready) begin
        @(posedge clk);
        break;
      end
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_run(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 23);
      if ($urandom_range(0, 9) < 8)
        send(1'($urandom_range(0, 1)), key_file[k], key_page[k], $urandom);
      else
        send(1'($urandom_range(0, 1)), 16'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin
    for (int k = 0; k < 24; k++) begin
      key_file[k] = (k < 12) ? 16'(k) : 16'($urandom);
      key_page[k] = (k < 12) ? 32'(k % 5) : $urandom;
    end
    key_file[0] = 16'hFFFF; key_page[0] = 32'hFFFF_FFFF;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset defaults, LRU with full pool
    send(pbr_pkg::KIND_GET, 16'h0000, 32'h0, 32'hFFFF_FFFF);   // miss on empty pool
    send(pbr_pkg::KIND_PUT, 16'h0000, 32'h0, 32'hFFFF_FFFF);
    send(pbr_pkg::KIND_GET, 16'h0000, 32'h0, 32'h0);           // hit
    send(pbr_pkg::KIND_PUT, 16'h0000, 32'h0, 32'h1234_5678);   // update in place
    send(pbr_pkg::KIND_GET, 16'h0000, 32'h0, 32'h0);
    send(pbr_pkg::KIND_PUT, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
    send(pbr_pkg::KIND_GET, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
    send(pbr_pkg::KIND_GET, 16'hFFFF, 32'h0, 32'h0);           // partial key match only
    for (int i = 0; i < 17; i++)
      send(pbr_pkg::KIND_PUT, 16'(i + 1), 32'(i), $urandom);  // overflow
    drain();
    // limit lowered below occupancy: one eviction per new put
    write_reg(pbr_pkg::CFG_SLOTS_IN_USE, 5'd2);
    send(pbr_pkg::KIND_PUT, 16'h0100, 32'h1, 32'h1);
    send(pbr_pkg::KIND_PUT, 16'h0101, 32'h1, 32'h2);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(pbr_pkg::CFG_REPLACE_MODE, 5'(modes[ph]));
      write_reg(pbr_pkg::CFG_SLOTS_IN_USE, 5'(limits[ph]));
      if (ph == 9) calm = 1;
      random_run(170);
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
